// ===== design/ngf_pkg.sv =====
// ----------------------------------------------------------------------------
// ngf_pkg: shared constants and helpers for the n-gram frequency counter
// Holds the sizes of the counter table, command codes and address helpers.
// ----------------------------------------------------------------------------
package ngf_pkg;

    localparam int ALPHABET_SIZE = 128;
    localparam int CODE_BITS     = 7;
    localparam int MAX_LEN       = 2;
    localparam int CODE_LIMIT    = 128;

    localparam int CHAR_W = 8;
    localparam int LEN_W  = 2;
    localparam int GRAM_W = 14;
    localparam int CNT_W  = 32;

    // Bank 1 holds single characters, bank 2 follows it and holds pairs.
    localparam int BANK2_BASE = ALPHABET_SIZE;
    localparam int TABLE_SIZE = ALPHABET_SIZE + ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);

    localparam logic [CNT_W-1:0] SAT_MAX = '1;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Table address of a gram of the given length; prev is the older code.
    function automatic logic [ADDR_W-1:0] gram_addr(
        input logic [LEN_W-1:0]     len,
        input logic [CODE_BITS-1:0] prev,
        input logic [CODE_BITS-1:0] code
    );
        logic [ADDR_W-1:0] addr;
        if (len == LEN_W'(1)) begin
            addr = ADDR_W'(code);
        end else begin
            addr = ADDR_W'(BANK2_BASE) + ADDR_W'({prev, code});
        end
        return addr;
    endfunction

endpackage

// ===== design/ngf_if.sv =====
// ----------------------------------------------------------------------------
// ngf_if: stream interfaces of the n-gram frequency counter
// One interface for the command stream, one for the query results.
// ----------------------------------------------------------------------------
interface ngf_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [ngf_pkg::CHAR_W-1:0]  char_code;
    logic [ngf_pkg::LEN_W-1:0]   gram_length;
    logic [ngf_pkg::GRAM_W-1:0]  gram_code;

    modport source (output valid, cmd, char_code, gram_length, gram_code, input ready);
    modport sink   (input valid, cmd, char_code, gram_length, gram_code, output ready);
endinterface

interface ngf_out_if;
    logic                        valid;
    logic                        ready;
    logic [ngf_pkg::CNT_W-1:0]   gram_count;
    logic [ngf_pkg::CNT_W-1:0]   total_chars;

    modport source (output valid, gram_count, total_chars, input ready);
    modport sink   (input valid, gram_count, total_chars, output ready);
endinterface

// ===== design/ngf_ram.sv =====
// ----------------------------------------------------------------------------
// ngf_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ngf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/ngf_satinc.sv =====
// ----------------------------------------------------------------------------
// ngf_satinc: saturating 32-bit incrementer
// Shared by the gram counters and the character total.
// ----------------------------------------------------------------------------
module ngf_satinc (
    input  logic [ngf_pkg::CNT_W-1:0] i_value,
    output logic [ngf_pkg::CNT_W-1:0] o_value
);

    always_comb begin
        if (i_value == ngf_pkg::SAT_MAX) begin
            o_value = i_value;
        end else begin
            o_value = i_value + ngf_pkg::CNT_W'(1);
        end
    end

endmodule

// ===== design/ngram_frequency_counter.sv =====
// ----------------------------------------------------------------------------
// ngram_frequency_counter: character n-gram histogram over a byte stream
// Counts single characters and character pairs in one table and answers
// queries for the count of a gram together with the character total.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  i_in     sink       cmd, char_code, gram_length, gram_code
//  o_res    source     gram_count, total_chars (one per query)
//
//  A counted character passes through the accepting cycle, a read and a
//  write-back per gram length through the single table port pair and the
//  shared incrementer, and a step for the total; an ignored one is only accepted.
//  A query passes through address, read and result steps. After reset a clearing
//  pass zeroes all 16512 table entries; i_in is not ready meanwhile. A query
//  that finishes while the previous result is still untaken holds until o_res frees.
module ngram_frequency_counter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ngf_in_if.sink     i_in,
    ngf_out_if.source  o_res
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_MOD, S_TOTAL, S_QREAD, S_QDATA
    } t_state;

    t_state                             r_state;
    logic [ngf_pkg::ADDR_W-1:0]         r_clr_addr;
    logic [ngf_pkg::LEN_W-1:0]          r_len;
    logic [ngf_pkg::CODE_BITS-1:0]      r_code;
    logic [ngf_pkg::CODE_BITS-1:0]      r_hist;
    logic [ngf_pkg::CNT_W-1:0]          r_total;
    logic                               r_ended;
    logic [ngf_pkg::ADDR_W-1:0]         r_qaddr;
    logic                               r_qzero;
    logic                               r_out_valid;
    logic [ngf_pkg::CNT_W-1:0]          r_out_count;
    logic [ngf_pkg::CNT_W-1:0]          r_out_total;

    logic                               in_accept;
    logic                               out_free;
    logic [ngf_pkg::ADDR_W-1:0]         char_addr;
    logic [ngf_pkg::ADDR_W-1:0]         query_addr;
    logic                               query_ok;
    logic                               ram_wr_en;
    logic [ngf_pkg::ADDR_W-1:0]         ram_wr_addr;
    logic [ngf_pkg::CNT_W-1:0]          ram_wr_data;
    logic                               ram_rd_en;
    logic [ngf_pkg::ADDR_W-1:0]         ram_rd_addr;
    logic [ngf_pkg::CNT_W-1:0]          ram_rd_data;
    logic [ngf_pkg::CNT_W-1:0]          inc_in;
    logic [ngf_pkg::CNT_W-1:0]          inc_out;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_accept   = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_res.ready;

    assign o_res.valid       = r_out_valid;
    assign o_res.gram_count  = r_out_count;
    assign o_res.total_chars = r_out_total;

    assign char_addr = ngf_pkg::gram_addr(r_len, r_hist, r_code);

    assign query_ok = (i_in.gram_length != '0) &&
                      (i_in.gram_length <= ngf_pkg::LEN_W'(ngf_pkg::MAX_LEN));
    assign query_addr = ngf_pkg::gram_addr(i_in.gram_length,
                            i_in.gram_code[2*ngf_pkg::CODE_BITS-1:ngf_pkg::CODE_BITS],
                            i_in.gram_code[ngf_pkg::CODE_BITS-1:0]);

    // The incrementer serves the table entry or the total, by state.
    assign inc_in = (r_state == S_TOTAL) ? r_total : ram_rd_data;

    ngf_satinc u_satinc (
        .i_value (inc_in),
        .o_value (inc_out)
    );

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = char_addr;
        ram_wr_data = inc_out;
        ram_rd_en   = 1'b0;
        ram_rd_addr = char_addr;
        case (r_state)
            S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_addr;
                ram_wr_data = '0;
            end
            S_READ: begin
                ram_rd_en = 1'b1;
            end
            S_MOD: begin
                ram_wr_en = 1'b1;
            end
            S_QREAD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_qaddr;
            end
            default: begin
            end
        endcase
    end

    ngf_ram #(
        .WIDTH (ngf_pkg::CNT_W),
        .DEPTH (ngf_pkg::TABLE_SIZE)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_hist      <= '0;
            r_total     <= '0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In S_QDATA the result register is handled by the state itself.
            if (r_out_valid && o_res.ready && r_state != S_QDATA) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ngf_pkg::ADDR_W'(1);
                    if (r_clr_addr == ngf_pkg::ADDR_W'(ngf_pkg::TABLE_SIZE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_in.cmd == ngf_pkg::CMD_QUERY) begin
                            r_qaddr <= query_addr;
                            r_qzero <= !query_ok;
                            r_state <= S_QREAD;
                        end else if (!r_ended) begin
                            if (i_in.char_code == '0) begin
                                r_ended <= 1'b1;
                            end else begin
                                if (i_in.char_code >= ngf_pkg::CHAR_W'(ngf_pkg::CODE_LIMIT)) begin
                                    r_code <= '0;
                                end else begin
                                    r_code <= i_in.char_code[ngf_pkg::CODE_BITS-1:0];
                                end
                                r_len   <= ngf_pkg::LEN_W'(1);
                                r_state <= S_READ;
                            end
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (r_len == ngf_pkg::LEN_W'(ngf_pkg::MAX_LEN)) begin
                        r_state <= S_TOTAL;
                    end else begin
                        r_len   <= r_len + ngf_pkg::LEN_W'(1);
                        r_state <= S_READ;
                    end
                end
                S_TOTAL: begin
                    r_total <= inc_out;
                    r_hist  <= r_code;
                    r_state <= S_IDLE;
                end
                S_QREAD: begin
                    r_state <= S_QDATA;
                end
                S_QDATA: begin
                    // The read data stays put until the result register frees up.
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_count <= r_qzero ? '0 : ram_rd_data;
                        r_out_total <= r_total;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/ngf_checker.sv =====
// ----------------------------------------------------------------------------
// ngf_checker: port-level checks for the n-gram frequency counter
// Watches the channels of the top level; bound to it below.
// ----------------------------------------------------------------------------
module ngf_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [ngf_pkg::CNT_W-1:0] i_gram_count,
    input logic [ngf_pkg::CNT_W-1:0] i_total_chars
);

    logic                      r_seen;
    logic [ngf_pkg::CNT_W-1:0] r_last_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (i_out_valid && i_out_ready) begin
            r_seen       <= 1'b1;
            r_last_total <= i_total_chars;
        end
    end

    // A waiting result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_gram_count) && $stable(i_total_chars))
        else $error("result changed while stalled");

    // The character total reported by successive results never goes down.
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && r_seen |-> i_total_chars >= r_last_total)
        else $error("total_chars decreased");

    // The table is being cleared right after reset.
    a_clear_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready during clearing pass");

    // A new result is raised only while a query is in progress.
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result raised while the input was idle");

endmodule

bind ngram_frequency_counter ngf_checker u_ngf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_gram_count  (o_res.gram_count),
    .i_total_chars (o_res.total_chars)
);
